@@ src/gdrc_pkg.sv @@
// Package: shared types and constants for the grid DDA ray caster.
package gdrc_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CAMDIV,
    ST_RAY,
    ST_RAYSUM,
    ST_DXDIV,
    ST_DYDIV,
    ST_SIDE,
    ST_WALK
  } gdrc_state_t;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_CAST = 1'b1;

  localparam logic [2:0] REG_PLAYER_X     = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y     = 3'd1;
  localparam logic [2:0] REG_VIEW_DIR_X   = 3'd2;
  localparam logic [2:0] REG_VIEW_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_COLUMN_COUNT = 3'd4;
  localparam logic [2:0] REG_FOV_SCALE    = 3'd5;

  localparam int DIV_STEPS = 31;

endpackage

@@ src/grid_dda_ray_caster_core.sv @@
// Grid DDA ray caster core: tile map in RAM, shared serial divider, DDA walk.
// A load item writes the map RAM when it is accepted. A cast item runs three
// 31-step divisions by the shared restoring divider, two ray states and one
// side state, then walks one DDA step per cycle (at most 2*MAP_SIZE+2 steps,
// one map RAM read each) and ends with a test for a hit or the step limit; the
// result strobe is registered from the walk's end and cannot be held off. One
// item at a time; after reset each map cell is cleared with busy high.
module grid_dda_ray_caster_core #(
  parameter int MAP_SIZE = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_action,
  input  logic [9:0]          in_column,
  input  logic [4:0]          in_cell_col,
  input  logic [4:0]          in_cell_row,
  input  logic [2:0]          in_cell_value,
  output logic                out_valid,
  output logic [23:0]         out_perp_distance,
  output logic                out_hit_side,
  output logic signed [6:0]   out_hit_col,
  output logic signed [6:0]   out_hit_row,
  output logic [2:0]          out_wall_value,
  output logic                out_left_map,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import gdrc_pkg::*;

  localparam int DEPTH      = MAP_SIZE * MAP_SIZE;
  localparam int AW         = $clog2(DEPTH);
  localparam int WALK_LIMIT = 2 * MAP_SIZE + 2;
  localparam int NW         = $clog2(WALK_LIMIT + 1);

  gdrc_state_t state_r, state_nxt;

  logic [20:0]        player_x_r, player_y_r;
  logic signed [15:0] view_dir_x_r, view_dir_y_r;
  logic [10:0]        column_count_r;
  logic [14:0]        fov_scale_r;

  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r     <= 21'd1441792;
      player_y_r     <= 21'd786432;
      view_dir_x_r   <= 16'sd16384;
      view_dir_y_r   <= 16'sd0;
      column_count_r <= 11'd640;
      fov_scale_r    <= 15'd9830;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_PLAYER_X:     player_x_r     <= pwdata[20:0];
        REG_PLAYER_Y:     player_y_r     <= pwdata[20:0];
        REG_VIEW_DIR_X:   view_dir_x_r   <= pwdata[15:0];
        REG_VIEW_DIR_Y:   view_dir_y_r   <= pwdata[15:0];
        REG_COLUMN_COUNT: column_count_r <= pwdata[10:0];
        REG_FOV_SCALE:    fov_scale_r    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_PLAYER_X:     prdata = {11'd0, player_x_r};
      REG_PLAYER_Y:     prdata = {11'd0, player_y_r};
      REG_VIEW_DIR_X:   prdata = {16'd0, view_dir_x_r};
      REG_VIEW_DIR_Y:   prdata = {16'd0, view_dir_y_r};
      REG_COLUMN_COUNT: prdata = {21'd0, column_count_r};
      REG_FOV_SCALE:    prdata = {17'd0, fov_scale_r};
      default:          prdata = 32'd0;
    endcase
  end

  // map RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, clr_addr_r;
  logic [2:0]    ram_wdata, ram_rdata;

  gdrc_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_map (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic accept, load_ok;
  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign load_ok = (int'(in_cell_col) < MAP_SIZE) && (int'(in_cell_row) < MAP_SIZE);

  // shared restoring divider
  logic [31:0] div_rem_r, div_den_r, rem_step;
  logic [30:0] div_quo_r, quo_step;
  logic [4:0]  div_cnt_r;
  logic [32:0] div_t;
  logic        div_ge, div_last;

  always_comb begin
    div_t    = {div_rem_r, div_quo_r[30]};
    div_ge   = div_t >= {1'b0, div_den_r};
    rem_step = div_ge ? 32'(div_t - {1'b0, div_den_r}) : div_t[31:0];
    quo_step = {div_quo_r[29:0], div_ge};
    div_last = (div_cnt_r == 5'(DIV_STEPS - 1));
  end

  // ray set-up
  logic [10:0]        cnt_eff;
  logic signed [16:0] ndy, edx;
  logic signed [32:0] px_full, py_full;
  logic signed [18:0] plane_x_r, plane_y_r;
  logic signed [25:0] cam_r, cam_step;
  logic signed [44:0] prodx_r, prody_r;
  logic signed [31:0] rx_c, ry_c, rx_r, ry_r;
  logic [31:0]        rx_abs, ry_abs;
  logic [40:0]        dx_r, dy_r;

  always_comb begin
    cnt_eff  = (column_count_r == 11'd0) ? 11'd1 : column_count_r;
    ndy      = -{view_dir_y_r[15], view_dir_y_r};
    edx      = {view_dir_x_r[15], view_dir_x_r};
    px_full  = ndy * $signed({1'b0, fov_scale_r});
    py_full  = edx * $signed({1'b0, fov_scale_r});
    cam_step = $signed({1'b0, quo_step[24:0]}) - 26'sd16384;
    rx_c     = 32'(view_dir_x_r) + 32'($signed(prodx_r[44:14]));
    ry_c     = 32'(view_dir_y_r) + 32'($signed(prody_r[44:14]));
    rx_abs   = rx_c[31] ? 32'(-rx_c) : 32'(rx_c);
    ry_abs   = ry_r[31] ? 32'(-ry_r) : 32'(ry_r);
  end

  // first side distances
  logic [16:0] frac_x, frac_y;
  logic [47:0] prod_sx, prod_sy, side_x, side_y;

  always_comb begin
    frac_x  = rx_r[31] ? {1'b0, player_x_r[15:0]} : 17'h10000 - {1'b0, player_x_r[15:0]};
    frac_y  = ry_r[31] ? {1'b0, player_y_r[15:0]} : 17'h10000 - {1'b0, player_y_r[15:0]};
    prod_sx = frac_x * dx_r[30:0];
    prod_sy = frac_y * dy_r[30:0];
    side_x  = dx_r[40] ? {7'd0, frac_x, 24'd0} : {16'd0, prod_sx[47:16]};
    side_y  = dy_r[40] ? {7'd0, frac_y, 24'd0} : {16'd0, prod_sy[47:16]};
  end

  // DDA walk
  logic [47:0]       sx_r, sy_r, perp_r, sx_nxt, sy_nxt, perp_nxt;
  logic signed [7:0] mx_r, my_r, nx, ny;
  logic              side_r, side_nxt, pend_r;
  logic [NW-1:0]     n_r;
  logic              hit, at_limit, outside, walk_end;

  always_comb begin
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    nx     = mx_r;
    ny     = my_r;
    if (sx_r < sy_r) begin
      perp_nxt = sx_r;
      sx_nxt   = sx_r + {7'd0, dx_r};
      nx       = rx_r[31] ? mx_r - 8'sd1 : mx_r + 8'sd1;
      side_nxt = 1'b0;
    end else begin
      perp_nxt = sy_r;
      sy_nxt   = sy_r + {7'd0, dy_r};
      ny       = ry_r[31] ? my_r - 8'sd1 : my_r + 8'sd1;
      side_nxt = 1'b1;
    end
    outside  = (nx < 8'sd0) || (int'(nx) >= MAP_SIZE) || (ny < 8'sd0) || (int'(ny) >= MAP_SIZE);
    hit      = pend_r && (ram_rdata != 3'd0);
    at_limit = (n_r == NW'(WALK_LIMIT));
    walk_end = (state_r == ST_WALK) && (hit || at_limit || outside);
    ram_raddr = AW'(int'(ny) * MAP_SIZE + int'(nx));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = 3'd0;
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (accept && in_action == ACT_LOAD && load_ok) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(int'(in_cell_row) * MAP_SIZE + int'(in_cell_col));
      ram_wdata = in_cell_value;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (accept && in_action == ACT_CAST) state_nxt = ST_CAMDIV;
      ST_CAMDIV: if (div_last) state_nxt = ST_RAY;
      ST_RAY:    state_nxt = ST_RAYSUM;
      ST_RAYSUM: state_nxt = ST_DXDIV;
      ST_DXDIV:  if (div_last) state_nxt = ST_DYDIV;
      ST_DYDIV:  if (div_last) state_nxt = ST_SIDE;
      ST_SIDE:   state_nxt = ST_WALK;
      ST_WALK:   if (walk_end) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_valid  <= walk_end;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        div_quo_r <= {6'd0, in_column, 15'd0};
        div_rem_r <= '0;
        div_den_r <= {21'd0, cnt_eff};
        div_cnt_r <= '0;
        plane_x_r <= px_full[32:14];
        plane_y_r <= py_full[32:14];
      end
      ST_CAMDIV: begin
        div_quo_r <= quo_step;
        div_rem_r <= rem_step;
        div_cnt_r <= div_cnt_r + 5'd1;
        cam_r     <= cam_step;
      end
      ST_RAY: begin
        prodx_r <= plane_x_r * cam_r;
        prody_r <= plane_y_r * cam_r;
      end
      ST_RAYSUM: begin
        rx_r      <= rx_c;
        ry_r      <= ry_c;
        div_quo_r <= 31'h4000_0000;
        div_rem_r <= '0;
        div_den_r <= rx_abs;
        div_cnt_r <= '0;
      end
      ST_DXDIV: begin
        div_quo_r <= quo_step;
        div_rem_r <= rem_step;
        div_cnt_r <= div_cnt_r + 5'd1;
        if (div_last) begin
          dx_r      <= (rx_r == 32'sd0) ? 41'h100_0000_0000 : {10'd0, quo_step};
          div_quo_r <= 31'h4000_0000;
          div_rem_r <= '0;
          div_den_r <= ry_abs;
          div_cnt_r <= '0;
        end
      end
      ST_DYDIV: begin
        div_quo_r <= quo_step;
        div_rem_r <= rem_step;
        div_cnt_r <= div_cnt_r + 5'd1;
        dy_r      <= (ry_r == 32'sd0) ? 41'h100_0000_0000 : {10'd0, quo_step};
      end
      ST_SIDE: begin
        sx_r   <= side_x;
        sy_r   <= side_y;
        mx_r   <= $signed({3'd0, player_x_r[20:16]});
        my_r   <= $signed({3'd0, player_y_r[20:16]});
        perp_r <= '0;
        side_r <= 1'b0;
        n_r    <= '0;
        pend_r <= 1'b0;
      end
      ST_WALK: begin
        if (hit) begin
          out_perp_distance <= (|perp_r[47:24]) ? 24'hFF_FFFF : perp_r[23:0];
          out_hit_side      <= side_r;
          out_hit_col       <= mx_r[6:0];
          out_hit_row       <= my_r[6:0];
          out_wall_value    <= ram_rdata;
          out_left_map      <= 1'b0;
        end else if (at_limit) begin
          out_perp_distance <= (|perp_r[47:24]) ? 24'hFF_FFFF : perp_r[23:0];
          out_hit_side      <= side_r;
          out_hit_col       <= mx_r[6:0];
          out_hit_row       <= my_r[6:0];
          out_wall_value    <= 3'd0;
          out_left_map      <= 1'b1;
        end else begin
          sx_r   <= sx_nxt;
          sy_r   <= sy_nxt;
          mx_r   <= nx;
          my_r   <= ny;
          perp_r <= perp_nxt;
          side_r <= side_nxt;
          n_r    <= n_r + NW'(1);
          pend_r <= 1'b1;
          out_perp_distance <= (|perp_nxt[47:24]) ? 24'hFF_FFFF : perp_nxt[23:0];
          out_hit_side      <= side_nxt;
          out_hit_col       <= nx[6:0];
          out_hit_row       <= ny[6:0];
          out_wall_value    <= 3'd0;
          out_left_map      <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_out_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_WALK))
    else $error("result strobe without a walk");

  a_left_no_wall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_left_map && out_wall_value != 3'd0))
    else $error("wall value reported outside the map");

  a_no_write_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !ram_we)
    else $error("map written during a walk");

  a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !accept)
    else $error("item accepted during map clear");

endmodule

@@ src/gdrc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gdrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sim/grid_dda_ray_caster_core_test.sv @@
// Testbench for the grid DDA ray caster core: map loads, register settings and ray casts driven; cast results checked.
module grid_dda_ray_caster_core_test;
  import gdrc_pkg::*;

  typedef struct packed {
    logic [23:0] distance;
    logic        side;
    logic [6:0]  col;
    logic [6:0]  row;
    logic [2:0]  wall;
    logic        outside;
  } cast_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_action = ACT_LOAD;
  logic [9:0] in_column = '0;
  logic [4:0] in_cell_col = '0;
  logic [4:0] in_cell_row = '0;
  logic [2:0] in_cell_value = '0;
  logic out_valid;
  logic [23:0] out_perp_distance;
  logic out_hit_side;
  logic signed [6:0] out_hit_col;
  logic signed [6:0] out_hit_row;
  logic [2:0] out_wall_value;
  logic out_left_map;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  grid_dda_ray_caster_core i_dut (.*);

  always #5 clk = ~clk;

  logic [2:0] map_model [0:1023];
  logic [20:0] pos_x, pos_y;
  logic signed [15:0] dir_x, dir_y;
  logic [10:0] ncols;
  logic [14:0] fov;
  cast_res_t pending_casts[$];
  int errors = 0;
  int gap_pct = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic longint fshr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned inv_step(input longint r);
    longint unsigned m;
    if (r == 0) return 64'd1 << 40;
    m = (r < 0) ? -r : r;
    return (64'd1 << 30) / m;
  endfunction

  function automatic longint unsigned first_dist(input longint r, input logic [20:0] p,
                                                 input longint unsigned d);
    longint unsigned f, fr;
    f = p[15:0];
    fr = (r < 0) ? f : (65536 - f);
    return (fr * d) >> 16;
  endfunction

  function automatic cast_res_t cast_ray(input logic [9:0] column);
    longint cam, plx, ply, rx, ry, cnt, mx, my, stx, sty;
    longint unsigned dx, dy, sx, sy, perp;
    int side, outside;
    logic [2:0] wall;
    cast_res_t r;
    perp = 0; side = 0; outside = 1; wall = 0;
    cnt = (ncols == 0) ? 1 : ncols;
    cam = ((longint'(2 * column)) << 14) / cnt - 16384;
    plx = fshr(-longint'(dir_y) * longint'(fov), 14);
    ply = fshr(longint'(dir_x) * longint'(fov), 14);
    rx = dir_x + fshr(plx * cam, 14);
    ry = dir_y + fshr(ply * cam, 14);
    dx = inv_step(rx);
    dy = inv_step(ry);
    mx = pos_x >> 16;
    my = pos_y >> 16;
    stx = (rx < 0) ? -1 : 1;
    sty = (ry < 0) ? -1 : 1;
    sx = first_dist(rx, pos_x, dx);
    sy = first_dist(ry, pos_y, dy);
    for (int n = 0; n < 66; n++) begin
      if (sx < sy) begin
        perp = sx; sx += dx; mx += stx; side = 0;
      end else begin
        perp = sy; sy += dy; my += sty; side = 1;
      end
      if (mx < 0 || mx >= 32 || my < 0 || my >= 32) begin
        outside = 1;
        break;
      end
      wall = map_model[10'(my * 32 + mx)];
      if (wall != 0) begin
        outside = 0;
        break;
      end
    end
    if (outside) wall = 0;
    r.distance = (perp > 64'hFFFFFF) ? 24'hFFFFFF : perp[23:0];
    r.side = side[0];
    r.col = mx[6:0];
    r.row = my[6:0];
    r.wall = wall;
    r.outside = outside[0];
    return r;
  endfunction

  always @(posedge clk) begin
    cast_res_t w;
    if (rst_n && out_valid) begin
      if (pending_casts.size() == 0) begin
        report("unexpected result", out_perp_distance, 0);
      end else begin
        w = pending_casts.pop_front();
        if (out_perp_distance !== w.distance)
          report("perp_distance", out_perp_distance, w.distance);
        if (out_hit_side !== w.side) report("hit_side", out_hit_side, w.side);
        if (out_hit_col !== w.col) report("hit_col", out_hit_col, w.col);
        if (out_hit_row !== w.row) report("hit_row", out_hit_row, w.row);
        if (out_wall_value !== w.wall) report("wall_value", out_wall_value, w.wall);
        if (out_left_map !== w.outside) report("left_map", out_left_map, w.outside);
      end
    end
  end

  task automatic send_item(input logic act, input logic [9:0] column, input logic [4:0] c,
                           input logic [4:0] r, input logic [2:0] v);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_action <= act;
    in_column <= column;
    in_cell_col <= c;
    in_cell_row <= r;
    in_cell_value <= v;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (act == ACT_CAST) pending_casts.push_back(cast_ray(column));
    else map_model[{r, c}] = v;
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_casts.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    case (idx)
      REG_PLAYER_X: pos_x = val[20:0];
      REG_PLAYER_Y: pos_y = val[20:0];
      REG_VIEW_DIR_X: dir_x = val[15:0];
      REG_VIEW_DIR_Y: dir_y = val[15:0];
      REG_COLUMN_COUNT: ncols = val[10:0];
      REG_FOV_SCALE: fov = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [20:0] x, input logic [20:0] y, input logic [15:0] ddx,
                          input logic [15:0] ddy, input logic [10:0] n, input logic [14:0] f);
    drain();
    write_reg(REG_PLAYER_X, 32'(x));
    write_reg(REG_PLAYER_Y, 32'(y));
    write_reg(REG_VIEW_DIR_X, 32'(ddx));
    write_reg(REG_VIEW_DIR_Y, 32'(ddy));
    write_reg(REG_COLUMN_COUNT, 32'(n));
    write_reg(REG_FOV_SCALE, 32'(f));
    psel <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic test_directed;
    send_item(ACT_CAST, 10'd0, 5'd0, 5'd0, 3'd0);
    send_item(ACT_CAST, 10'd320, 5'd0, 5'd0, 3'd0);
    send_item(ACT_LOAD, 10'd0, 5'd31, 5'd12, 3'd7);
    send_item(ACT_LOAD, 10'd0, 5'd0, 5'd0, 3'd1);
    send_item(ACT_LOAD, 10'd0, 5'd31, 5'd31, 3'd0);
    send_item(ACT_CAST, 10'd320, 5'd0, 5'd0, 3'd0);
    send_item(ACT_CAST, 10'd1023, 5'd0, 5'd0, 3'd0);
    send_item(ACT_LOAD, 10'd0, 5'd22, 5'd12, 3'd3);
    send_item(ACT_CAST, 10'd639, 5'd0, 5'd0, 3'd0);
    send_item(ACT_LOAD, 10'd0, 5'd22, 5'd12, 3'd0);
    set_view(21'h1FFFFF, 21'h1FFFFF, 16'hC000, 16'h4000, 11'd0, 15'h7FFF);
    send_item(ACT_CAST, 10'd0, 5'd0, 5'd0, 3'd0);
    send_item(ACT_CAST, 10'd1023, 5'd0, 5'd0, 3'd0);
    set_view(21'd0, 21'd0, 16'd0, 16'd0, 11'd1024, 15'd0);
    send_item(ACT_CAST, 10'd512, 5'd0, 5'd0, 3'd0);
    set_view(21'h10000, 21'h10000, 16'd16384, 16'd16384, 11'd1, 15'd0);
    send_item(ACT_CAST, 10'd0, 5'd0, 5'd0, 3'd0);
    set_view(21'h108000, 21'h108000, 16'd0, 16'hC000, 11'd2, 15'd16384);
    send_item(ACT_CAST, 10'd1, 5'd0, 5'd0, 3'd0);
    send_item(ACT_CAST, 10'd3, 5'd0, 5'd0, 3'd0);
  endtask

  task automatic test_random(input int count, input int gp);
    gap_pct = gp;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 4) begin
        drain();
        set_view(21'($urandom_range(0, 21'h1FFFFF)), 21'($urandom_range(0, 21'h1FFFFF)),
                 16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                 11'(($urandom_range(3) == 0) ? $urandom_range(0, 2047)
                                              : $urandom_range(1, 1024)),
                 15'($urandom_range(0, 32767)));
      end
      if ($urandom_range(99) < 45)
        send_item(ACT_LOAD, 10'($urandom), 5'($urandom), 5'($urandom),
                  ($urandom_range(2) == 0) ? 3'd0 : 3'($urandom_range(1, 7)));
      else
        send_item(ACT_CAST, 10'($urandom), 5'($urandom), 5'($urandom), 3'($urandom));
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    pos_x = 21'd1441792; pos_y = 21'd786432; dir_x = 16384; dir_y = 0;
    ncols = 11'd640; fov = 15'd9830;
    for (int i = 0; i < 1024; i++) map_model[i] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(230, 21);
    test_random(230, 65);
    test_random(230, 0);
    drain();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end
endmodule

@@ grid_dda_ray_caster_core.f @@
src/gdrc_pkg.sv
src/gdrc_ram.sv
src/grid_dda_ray_caster_core.sv
sim/grid_dda_ray_caster_core_test.sv
